// ===== rtl/bbc_pkg.sv =====
// Package: shared constants, types and bracket decode functions for the bracket checker.
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam logic [7:0] END_MARKER_RST = 8'd35;

  localparam logic [7:0] CH_OPEN_PAR = 8'h28;
  localparam logic [7:0] CH_CLOSE_PAR = 8'h29;
  localparam logic [7:0] CH_OPEN_SQR = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQR = 8'h5D;
  localparam logic [7:0] CH_OPEN_CRL = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CRL = 8'h7D;
  localparam logic [7:0] CH_OPEN_ANG = 8'h3C;
  localparam logic [7:0] CH_CLOSE_ANG = 8'h3E;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    V_MISMATCH = 2'd0,
    V_OVERFLOW = 2'd1,
    V_BALANCED = 2'd2,
    V_MISSING  = 2'd3
  } verdict_t;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] code;
  } stk_op_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] code;
  } pair_t;

  function automatic pair_t opener_decode(input logic [7:0] c);
    pair_t p;
    p.hit = 1'b1;
    p.code = 2'd0;
    case (c)
      CH_OPEN_PAR: p.code = 2'd0;
      CH_OPEN_SQR: p.code = 2'd1;
      CH_OPEN_CRL: p.code = 2'd2;
      CH_OPEN_ANG: p.code = 2'd3;
      default:     p.hit = 1'b0;
    endcase
    return p;
  endfunction

  function automatic pair_t closer_decode(input logic [7:0] c);
    pair_t p;
    p.hit = 1'b1;
    p.code = 2'd0;
    case (c)
      CH_CLOSE_PAR: p.code = 2'd0;
      CH_CLOSE_SQR: p.code = 2'd1;
      CH_CLOSE_CRL: p.code = 2'd2;
      CH_CLOSE_ANG: p.code = 2'd3;
      default:      p.hit = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] closer_char(input logic [1:0] code);
    logic [7:0] c;
    unique case (code)
      2'd0:    c = CH_CLOSE_PAR;
      2'd1:    c = CH_CLOSE_SQR;
      2'd2:    c = CH_CLOSE_CRL;
      default: c = CH_CLOSE_ANG;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/bbc_if.sv =====
// Interfaces: character request, result request and end-marker write channels.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] position;
  logic [7:0]  char_out;
  logic        last;
  modport source (output valid, output verdict, output position, output char_out,
                  output last, input ready);
  modport sink (input valid, input verdict, input position, input char_out,
                input last, output ready);
endinterface

interface bbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] end_marker;
  modport source (output valid, output end_marker, input ready);
  modport sink (input valid, input end_marker, output ready);
endinterface

// ===== rtl/bbc_cell.sv =====
// One stack cell: holds a pair code, shifts down on push and up on pop.
module bbc_cell (
  input  logic            clk,
  input  bbc_pkg::stk_op_t op,
  input  logic [1:0]      from_prev,
  input  logic [1:0]      from_next,
  output logic [1:0]      code_r
);
  import bbc_pkg::*;

  logic [1:0] code_nxt;

  always_comb begin
    code_nxt = code_r;
    if (op.push) begin
      code_nxt = from_prev;
    end else if (op.pop) begin
      code_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

endmodule

// ===== rtl/bbc_stack.sv =====
// Bracket stack as a row of shifting cells; the top of stack sits in cell 0.
module bbc_stack #(
  parameter int DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  bbc_pkg::stk_op_t op,
  output logic [1:0]       top_code
);
  import bbc_pkg::*;

  logic [1:0] code [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [1:0] prev_code;
    logic [1:0] next_code;
    if (i == 0) begin : g_first
      assign prev_code = op.code;
    end else begin : g_mid
      assign prev_code = code[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign next_code = 2'd0;
    end else begin : g_inner
      assign next_code = code[i+1];
    end
    bbc_cell u_cell (
      .clk       (clk),
      .op        (op),
      .from_prev (prev_code),
      .from_next (next_code),
      .code_r    (code[i])
    );
  end

  assign top_code = code[0];

endmodule

// ===== rtl/bracket_balance_checker_top.sv =====
// Top level: bracket balance checker with a shifting cell stack and registered result output.
// One character is taken per cycle; openers push and matching closers pop the cell row in
// that cycle. An end marker with N open brackets left, and no mismatch since the last end
// marker, yields N missing-closer results, one per cycle while each is taken, as the row
// shifts up; no character is taken during that drain. Any cycle in which a result waits
// untaken holds off the next character. The end marker register can be written in any cycle.
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bbc_in_if.sink      in_if,
  bbc_out_if.source   out_if,
  bbc_cfg_if.sink     cfg_if
);
  import bbc_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] stk_cnt_r, stk_cnt_nxt;
  logic [15:0]      char_cnt_r, char_cnt_nxt;
  logic [15:0]      end_pos_r, end_pos_nxt;
  logic             skip_r, skip_nxt;
  logic [7:0]       end_marker_r;

  logic             out_valid_r, out_valid_nxt;
  verdict_t         verdict_r, verdict_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [7:0]       char_out_r, char_out_nxt;
  logic             last_r, last_nxt;

  logic             out_free;
  logic             accept;
  logic             is_end;
  logic [15:0]      cnt_inc;
  pair_t            opn, cls;
  stk_op_t          op;
  logic [1:0]       top_code;
  logic             emit;

  bbc_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk      (clk),
    .op       (op),
    .top_code (top_code)
  );

  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_RUN) && out_free;
  assign accept = in_if.valid && in_if.ready;
  assign is_end = (in_if.char_in == end_marker_r);
  assign cnt_inc = (char_cnt_r == POS_MAX) ? char_cnt_r : char_cnt_r + 16'd1;
  assign opn = opener_decode(in_if.char_in);
  assign cls = closer_decode(in_if.char_in);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept && is_end && !skip_r && (stk_cnt_r != '0)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free && (stk_cnt_r == CNT_ONE)) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    stk_cnt_nxt  = stk_cnt_r;
    char_cnt_nxt = char_cnt_r;
    end_pos_nxt  = end_pos_r;
    skip_nxt     = skip_r;
    op.push      = 1'b0;
    op.pop       = 1'b0;
    op.code      = opn.code;
    emit         = 1'b0;
    verdict_nxt  = verdict_r;
    pos_nxt      = pos_r;
    char_out_nxt = char_out_r;
    last_nxt     = last_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          char_cnt_nxt = cnt_inc;
          pos_nxt      = cnt_inc;
          char_out_nxt = in_if.char_in;
          last_nxt     = 1'b1;
          if (is_end) begin
            char_cnt_nxt = '0;
            skip_nxt     = 1'b0;
            end_pos_nxt  = cnt_inc;
            if (!skip_r && (stk_cnt_r == '0)) begin
              emit        = 1'b1;
              verdict_nxt = V_BALANCED;
            end
            if (skip_r) begin
              stk_cnt_nxt = '0;
            end
          end else if (!skip_r) begin
            if (opn.hit) begin
              if (stk_cnt_r == CNT_FULL) begin
                emit        = 1'b1;
                verdict_nxt = V_OVERFLOW;
              end else begin
                op.push     = 1'b1;
                stk_cnt_nxt = stk_cnt_r + CNT_ONE;
              end
            end else if (cls.hit) begin
              if ((stk_cnt_r != '0) && (top_code == cls.code)) begin
                op.pop      = 1'b1;
                stk_cnt_nxt = stk_cnt_r - CNT_ONE;
              end else begin
                emit        = 1'b1;
                verdict_nxt = V_MISMATCH;
                skip_nxt    = 1'b1;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit         = 1'b1;
          op.pop       = 1'b1;
          stk_cnt_nxt  = stk_cnt_r - CNT_ONE;
          verdict_nxt  = V_MISSING;
          pos_nxt      = end_pos_r;
          char_out_nxt = closer_char(top_code);
          last_nxt     = (stk_cnt_r == CNT_ONE);
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      stk_cnt_r    <= '0;
      char_cnt_r   <= '0;
      skip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      end_marker_r <= END_MARKER_RST;
    end else begin
      state_r     <= state_nxt;
      stk_cnt_r   <= stk_cnt_nxt;
      char_cnt_r  <= char_cnt_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        end_marker_r <= cfg_if.end_marker;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_pos_r  <= end_pos_nxt;
    verdict_r  <= verdict_nxt;
    pos_r      <= pos_nxt;
    char_out_r <= char_out_nxt;
    last_r     <= last_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.verdict  = verdict_r;
  assign out_if.position = pos_r;
  assign out_if.char_out = char_out_r;
  assign out_if.last     = last_r;

endmodule

// ===== rtl/bbc_checker.sv =====
// Checker: port-level assertions for the bracket checker, bound to the top level.
module bbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_verdict,
  input logic [15:0] out_position,
  input logic        out_last
);
  import bbc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position))
    else $error("result dropped or changed while stalled");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("character taken while result register blocked");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_verdict == V_BALANCED) || (out_verdict == V_MISMATCH) ||
                  (out_verdict == V_OVERFLOW)) |-> out_last)
    else $error("single-result verdict without last");

  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_verdict == V_MISSING) && !out_last |-> !in_ready)
    else $error("character taken during missing-closer drain");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position != 16'd0)
    else $error("result with zero position");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_verdict  (out_if.verdict),
  .out_position (out_if.position),
  .out_last     (out_if.last)
);
